// ----- design/csd_pkg.sv -----
// ----------------------------------------------------------------------------
// csd_pkg: shared types and constants for the cascaded divisor search
// Holds field widths, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package csd_pkg;

	localparam int unsigned COUNTER_MAX_DEF = 65535;

	localparam int unsigned PERIOD_W = 32;	// request and achieved period
	localparam int unsigned DIV_W    = 16;	// one counter divisor
	localparam int unsigned CLK_W    = 10;	// master clock period
	localparam int unsigned MDIV_W   = DIV_W + CLK_W;			// i * clock
	localparam int unsigned PROD_W   = DIV_W + DIV_W + CLK_W;	// i * j * clock
	localparam int unsigned MUL_A_W  = 32;
	localparam int unsigned MUL_B_W  = 16;
	localparam int unsigned MUL_W    = MUL_A_W + MUL_B_W;
	localparam int unsigned STEP_W   = $clog2(PERIOD_W);

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(200);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD_AB,		// kept first * kept second
		ST_PROD_ABC,	// ... * clock
		ST_CHECK,		// kept pair exact or search over, else start the bound division
		ST_DIV_MAX,		// period / (2 * clock)
		ST_RANGE,		// clamp the bound, open the loop
		ST_LOOP_MUL,	// i * clock, loads the divider
		ST_DIV_Q,		// period / (i * clock)
		ST_CAND,		// form second divisor, range check
		ST_CAND_MUL,	// (i * clock) * j
		ST_ERR,			// absolute error
		ST_CMP,			// keep if strictly closer
		ST_RESULT		// hand item to output register
	} state_t;

endpackage

// ----- design/cascaded_divisor_search_unit.sv -----
// ----------------------------------------------------------------------------
// cascaded_divisor_search_unit: two-counter divisor search
// Picks the pair of cascaded counter divisors whose product times the
// master clock period lands closest to a requested period.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / period_ns) takes one request item.
//   in_stall is high for the whole search; one item is worked on at a time.
//   Output channel (out_valid / out_stall) carries achieved_period_ns,
//   divisor_first, divisor_second and exact_match from an output register,
//   so a new request is taken while the last result still waits.
//   cfg_wr_en / cfg_wr_data load the clock period (0 is used as 1); write
//   it only while the unit is idle.
// Sequence:
//   Kept pair already exact: accept, ST_PROD_AB, ST_PROD_ABC, ST_CHECK,
//   then ST_RESULT and the result register. Full search: N first divisors
//   tried (up to COUNTER_MAX - 1), then the reported product is formed. Each
//   first divisor costs one 32-step restoring division, which dominates.
// Reset:
//   Clears the kept pair to zero, clock period to 200, no item in flight.
// Stall:
//   A finished result waits in ST_RESULT while the output register is full
//   and stalled; nothing is dropped.
// ----------------------------------------------------------------------------
module cascaded_divisor_search_unit
	import csd_pkg::*;
#(
	parameter int unsigned COUNTER_MAX = COUNTER_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_wr_en,
	input  logic [CLK_W-1:0]    cfg_wr_data,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [PERIOD_W-1:0] period_ns,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [PERIOD_W-1:0] achieved_period_ns,
	output logic [DIV_W-1:0]    divisor_first,
	output logic [DIV_W-1:0]    divisor_second,
	output logic                exact_match
);

	localparam logic [DIV_W-1:0] CMAX = DIV_W'(COUNTER_MAX);
	localparam logic [DIV_W-1:0] DIV_MIN = DIV_W'(2);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PERIOD_W - 1);

	state_t state_q, state_d;

	// configuration and kept pair
	logic [CLK_W-1:0]    clock_period_q;
	logic [DIV_W-1:0]    kept_first_q, kept_second_q;

	// per item
	logic [PERIOD_W-1:0] period_q;
	logic [CLK_W-1:0]    clk_q;		// effective clock period, never 0
	logic                final_q;	// search over, compute reported product
	logic [PERIOD_W-1:0] ab_q;
	logic [PROD_W-1:0]   prod_q;
	logic [PROD_W-1:0]   err_q;
	logic [PROD_W-1:0]   best_q;
	logic [DIV_W-1:0]    max_i_q;
	logic [DIV_W-1:0]    i_q;
	logic [DIV_W-1:0]    j_q;
	logic                k_q;

	// shared restoring divider: dq_q holds dividend, then quotient
	logic [PERIOD_W-1:0] dq_q;
	logic [MDIV_W-1:0]   rem_q;
	logic [MDIV_W-1:0]   div_d_q;	// divisor; i * clock also feeds the candidate mul
	logic [STEP_W-1:0]   step_q;

	// output register
	logic                out_valid_q;
	logic [PERIOD_W-1:0] out_period_q;
	logic [DIV_W-1:0]    out_first_q, out_second_q;
	logic                out_exact_q;

	// shared multiplier
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_W-1:0]    mul_res;

	// divider step
	logic [MDIV_W:0]     rem_sh, d_ext, rem_n;
	logic                div_ge;
	logic [PERIOD_W-1:0] dq_n;
	logic                div_last;

	// candidate logic
	logic [PERIOD_W:0]   j_wide;
	logic                j_ok;
	logic                cmp_better;
	logic                cmp_exact;
	logic                last_i;
	logic                out_free;
	logic                in_acc;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid          = out_valid_q;
	assign achieved_period_ns = out_period_q;
	assign divisor_first      = out_first_q;
	assign divisor_second     = out_second_q;
	assign exact_match        = out_exact_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_PROD_AB: begin
				mul_a = MUL_A_W'(kept_first_q);
				mul_b = kept_second_q;
			end
			ST_PROD_ABC: begin
				mul_a = ab_q;
				mul_b = MUL_B_W'(clk_q);
			end
			ST_LOOP_MUL: begin
				mul_a = MUL_A_W'(i_q);
				mul_b = MUL_B_W'(clk_q);
			end
			ST_CAND_MUL: begin
				mul_a = MUL_A_W'(div_d_q);
				mul_b = j_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_res = MUL_W'(mul_a) * MUL_W'(mul_b);
	end

	always_comb begin
		rem_sh   = {rem_q, dq_q[PERIOD_W-1]};
		d_ext    = {1'b0, div_d_q};
		div_ge   = (rem_sh >= d_ext);
		rem_n    = div_ge ? (rem_sh - d_ext) : rem_sh;
		dq_n     = {dq_q[PERIOD_W-2:0], div_ge};
		div_last = (step_q == LAST_STEP);
	end

	always_comb begin
		j_wide     = {1'b0, dq_q} + (PERIOD_W+1)'(k_q);
		j_ok       = (j_wide >= (PERIOD_W+1)'(DIV_MIN)) && (j_wide <= (PERIOD_W+1)'(CMAX));
		cmp_better = (err_q < best_q);
		cmp_exact  = (err_q == '0);
		last_i     = (i_q == max_i_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_PROD_AB;
			end
			ST_PROD_AB:  state_d = ST_PROD_ABC;
			ST_PROD_ABC: state_d = ST_CHECK;
			ST_CHECK: begin
				if (final_q || prod_q == PROD_W'(period_q)) state_d = ST_RESULT;
				else state_d = ST_DIV_MAX;
			end
			ST_DIV_MAX: begin
				if (div_last) state_d = ST_RANGE;
			end
			ST_RANGE: begin
				if (dq_q < PERIOD_W'(DIV_MIN)) state_d = ST_PROD_AB;
				else state_d = ST_LOOP_MUL;
			end
			ST_LOOP_MUL: state_d = ST_DIV_Q;
			ST_DIV_Q: begin
				if (div_last) state_d = ST_CAND;
			end
			ST_CAND: begin
				if (j_ok) state_d = ST_CAND_MUL;
				else if (!k_q) state_d = ST_CAND;
				else if (last_i) state_d = ST_PROD_AB;
				else state_d = ST_LOOP_MUL;
			end
			ST_CAND_MUL: state_d = ST_ERR;
			ST_ERR:      state_d = ST_CMP;
			ST_CMP: begin
				if (cmp_better && cmp_exact) state_d = ST_PROD_AB;
				else if (!k_q) state_d = ST_CAND;
				else if (last_i) state_d = ST_PROD_AB;
				else state_d = ST_LOOP_MUL;
			end
			ST_RESULT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and kept state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_period_q <= CLK_RESET;
			kept_first_q   <= '0;
			kept_second_q  <= '0;
			final_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) clock_period_q <= cfg_wr_data;

			if (state_q == ST_CMP && cmp_better) begin
				kept_first_q  <= i_q;
				kept_second_q <= j_q;
			end

			if (in_acc) final_q <= 1'b0;
			else if (state_d == ST_PROD_AB && state_q != ST_IDLE) final_q <= 1'b1;

			if (state_q == ST_RESULT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			period_q <= period_ns;
			clk_q    <= (clock_period_q == '0) ? CLK_W'(1) : clock_period_q;
		end

		unique case (state_q)
			ST_PROD_AB:  ab_q   <= mul_res[PERIOD_W-1:0];
			ST_PROD_ABC: prod_q <= mul_res[PROD_W-1:0];
			ST_CHECK: begin
				best_q  <= PROD_W'(period_q);
				dq_q    <= period_q;
				rem_q   <= '0;
				step_q  <= '0;
				div_d_q <= MDIV_W'({clk_q, 1'b0});
			end
			ST_DIV_MAX, ST_DIV_Q: begin
				dq_q   <= dq_n;
				rem_q  <= rem_n[MDIV_W-1:0];
				step_q <= step_q + STEP_W'(1);
			end
			ST_RANGE: begin
				max_i_q <= (dq_q > PERIOD_W'(CMAX)) ? CMAX : dq_q[DIV_W-1:0];
				i_q     <= DIV_MIN;
				k_q     <= 1'b0;
			end
			ST_LOOP_MUL: begin
				dq_q    <= period_q;
				rem_q   <= '0;
				step_q  <= '0;
				div_d_q <= mul_res[MDIV_W-1:0];
			end
			ST_CAND: begin
				j_q <= j_wide[DIV_W-1:0];
				if (!j_ok) begin
					if (!k_q) begin
						k_q <= 1'b1;
					end else begin
						k_q <= 1'b0;
						i_q <= i_q + DIV_W'(1);
					end
				end
			end
			ST_CAND_MUL: prod_q <= mul_res[PROD_W-1:0];
			ST_ERR: begin
				err_q <= (prod_q > PROD_W'(period_q)) ? (prod_q - PROD_W'(period_q))
				                                      : (PROD_W'(period_q) - prod_q);
			end
			ST_CMP: begin
				if (cmp_better) best_q <= err_q;
				if (!k_q) begin
					k_q <= 1'b1;
				end else begin
					k_q <= 1'b0;
					i_q <= i_q + DIV_W'(1);
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					out_period_q <= (|prod_q[PROD_W-1:PERIOD_W]) ? '1 : prod_q[PERIOD_W-1:0];
					out_first_q  <= kept_first_q;
					out_second_q <= kept_second_q;
					out_exact_q  <= (prod_q == PROD_W'(period_q));
				end
			end
			default: begin
			end
		endcase
	end

endmodule
